// ----- rtl/intel_hex_record_encoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// Intel HEX record encoder assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled while
// rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_ENCODER_TOP_ASSERT_SVH
`define INTEL_HEX_RECORD_ENCODER_TOP_ASSERT_SVH

// Plain property check.
`define IHX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication check.
`define IHX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ihx_pkg.sv -----
// ----------------------------------------------------------------------------
// Intel HEX encoder package
// Operation codes, character constants and hex/text helpers.
// ----------------------------------------------------------------------------
package ihx_pkg;

  // byte counter width: holds a record count of up to 31 bytes
  localparam int unsigned CNT_W = 5;

  // operation codes of the input transaction
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_EOF   = 8'h1A;

  // end record text: ":0000000000", newline, end-of-file byte
  localparam int unsigned END_LEN = 13;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = 8'h37 + {4'b0, d};
    end
    return c;
  endfunction

  function automatic logic [7:0] end_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = CH_COLON;
      4'd11:   c = CH_NL;
      4'd12:   c = CH_EOF;
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ihx_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ihx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/intel_hex_record_encoder_top.sv -----
// ----------------------------------------------------------------------------
// Intel HEX record encoder
// Collects code bytes into records and streams them out as Intel HEX text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transaction carries op_i,
//   data_byte_i and address_i. op 0 appends a byte, op 1 flushes the open
//   record and sets the next load address, op 2 flushes and adds the end
//   record. Output channel (out_valid_o / out_stall_i): one ASCII character
//   per transaction, last_o marks the final character of an input item.
//   A data byte that does not fill the record gives no output. A record
//   holds the block from its accept cycle through 9 header characters,
//   two digits per byte with a RAM read turnaround before every byte but
//   the first (byte 0 is read during the header), two checksum digits and
//   a newline. The end record adds its 13 characters.
//   The block takes one item at a time: in_stall_o is high while a record
//   streams. The output register lets the next item be taken while the last
//   character still waits.
//   Reset: empty record, load address 0, output channel empty.
//   Receiver stall: the output register holds and character generation
//   pauses; no character is dropped.
// ----------------------------------------------------------------------------
`include "intel_hex_record_encoder_top_assert.svh"

module intel_hex_record_encoder_top #(
  parameter int unsigned RECORD_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        last_o
);
  import ihx_pkg::*;

  localparam int unsigned AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RECORD_BYTES);
  localparam logic [3:0] HDR_LAST = 4'd8;
  localparam logic [3:0] END_LAST = 4'(END_LEN - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_DATA_HI, S_DATA_LO, S_CHK_HI, S_CHK_LO, S_NL, S_END
  } state_e;

  state_e           state_q;
  logic [3:0]       pos_q;
  logic [CNT_W-1:0] idx_q;
  logic             fresh_q;
  logic             end_q;
  logic [CNT_W-1:0] rec_count_q;
  logic [15:0]      rec_addr_q;
  logic [7:0]       rec_chk_q;
  logic [CNT_W-1:0] byte_count_q;
  logic [15:0]      load_q;
  logic [7:0]       sum_q;
  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             out_last_q;

  logic             in_acc;
  logic             emit_ok;
  logic             ram_we;
  logic [7:0]       rd_data;
  logic [7:0]       sum_add;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       chk_full;
  logic [7:0]       chk_open;
  logic [15:0]      addr_inc;
  logic [7:0]       hdr_char;
  logic [7:0]       rec_cnt_byte;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // output register is free, or its character leaves this cycle
  assign emit_ok    = !out_valid_q || !out_stall_i;

  assign sum_add  = sum_q + data_byte_i;
  assign cnt_inc  = byte_count_q + CNT_W'(1);
  // checksum: two's complement of count plus address bytes plus data
  assign chk_full = 8'(0) - (sum_add + 8'(cnt_inc));
  assign chk_open = 8'(0) - (sum_q + 8'(byte_count_q));
  assign addr_inc = address_i + 16'd1;
  assign ram_we   = in_acc && (op_i == OP_DATA);

  ihx_ram #(
    .WIDTH (8),
    .DEPTH (RECORD_BYTES)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (byte_count_q[AW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign rec_cnt_byte = 8'(rec_count_q);

  // header: ':', count, address high, address low, record type 00
  always_comb begin
    case (pos_q)
      4'd0:    hdr_char = CH_COLON;
      4'd1:    hdr_char = hex_char(rec_cnt_byte[7:4]);
      4'd2:    hdr_char = hex_char(rec_cnt_byte[3:0]);
      4'd3:    hdr_char = hex_char(rec_addr_q[15:12]);
      4'd4:    hdr_char = hex_char(rec_addr_q[11:8]);
      4'd5:    hdr_char = hex_char(rec_addr_q[7:4]);
      4'd6:    hdr_char = hex_char(rec_addr_q[3:0]);
      default: hdr_char = CH_ZERO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pos_q        <= '0;
      idx_q        <= '0;
      fresh_q      <= 1'b0;
      end_q        <= 1'b0;
      rec_count_q  <= '0;
      rec_addr_q   <= '0;
      rec_chk_q    <= '0;
      byte_count_q <= '0;
      load_q       <= '0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
      out_char_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      // drop the character once it is taken; a new one overrides below
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (op_i)
              OP_DATA: begin
                byte_count_q <= cnt_inc;
                sum_q        <= sum_add;
                if (cnt_inc == FULL_CNT) begin
                  // record full: snapshot it and open the next at address + 1
                  rec_count_q  <= cnt_inc;
                  rec_addr_q   <= load_q;
                  rec_chk_q    <= chk_full;
                  byte_count_q <= '0;
                  load_q       <= addr_inc;
                  sum_q        <= addr_inc[15:8] + addr_inc[7:0];
                  end_q        <= 1'b0;
                  pos_q        <= '0;
                  idx_q        <= '0;
                  state_q      <= S_HDR;
                end
              end
              OP_FLUSH: begin
                rec_count_q  <= byte_count_q;
                rec_addr_q   <= load_q;
                rec_chk_q    <= chk_open;
                byte_count_q <= '0;
                load_q       <= address_i;
                sum_q        <= address_i[15:8] + address_i[7:0];
                end_q        <= 1'b0;
                pos_q        <= '0;
                idx_q        <= '0;
                if (byte_count_q != '0) begin
                  state_q <= S_HDR;
                end
              end
              OP_END: begin
                rec_count_q  <= byte_count_q;
                rec_addr_q   <= load_q;
                rec_chk_q    <= chk_open;
                byte_count_q <= '0;
                load_q       <= '0;
                sum_q        <= '0;
                end_q        <= 1'b1;
                pos_q        <= '0;
                idx_q        <= '0;
                state_q      <= (byte_count_q != '0) ? S_HDR : S_END;
              end
              default: begin
              end
            endcase
          end
        end
        S_HDR: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_char_q  <= hdr_char;
            out_last_q  <= 1'b0;
            if (pos_q == HDR_LAST) begin
              // read of byte 0 has long since settled
              pos_q   <= '0;
              fresh_q <= 1'b1;
              state_q <= S_DATA_HI;
            end else begin
              pos_q <= pos_q + 4'd1;
            end
          end
        end
        S_DATA_HI: begin
          if (!fresh_q) begin
            // wait out the RAM read after an index change
            fresh_q <= 1'b1;
          end else if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_char_q  <= hex_char(rd_data[7:4]);
            out_last_q  <= 1'b0;
            state_q     <= S_DATA_LO;
          end
        end
        S_DATA_LO: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_char_q  <= hex_char(rd_data[3:0]);
            out_last_q  <= 1'b0;
            if (idx_q == rec_count_q - CNT_W'(1)) begin
              state_q <= S_CHK_HI;
            end else begin
              idx_q   <= idx_q + CNT_W'(1);
              fresh_q <= 1'b0;
              state_q <= S_DATA_HI;
            end
          end
        end
        S_CHK_HI: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_char_q  <= hex_char(rec_chk_q[7:4]);
            out_last_q  <= 1'b0;
            state_q     <= S_CHK_LO;
          end
        end
        S_CHK_LO: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_char_q  <= hex_char(rec_chk_q[3:0]);
            out_last_q  <= 1'b0;
            state_q     <= S_NL;
          end
        end
        S_NL: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_char_q  <= CH_NL;
            out_last_q  <= !end_q;
            pos_q       <= '0;
            state_q     <= end_q ? S_END : S_IDLE;
          end
        end
        S_END: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_char_q  <= end_char(pos_q);
            out_last_q  <= (pos_q == END_LAST);
            if (pos_q == END_LAST) begin
              pos_q   <= '0;
              end_q   <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              pos_q <= pos_q + 4'd1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  // open record never holds a full record between items
  `IHX_ASSERT(a_count_below_full, byte_count_q < FULL_CNT,
              "open record reached full size")
  // a byte that does not fill the record produces no output sequence
  `IHX_ASSERT(a_partial_stays_idle,
              (in_acc && (op_i == OP_DATA) && (cnt_inc != FULL_CNT)) |=> (state_q == S_IDLE),
              "partial record started output")
  // data read index stays inside the snapshot record
  `IHX_ASSERT_IMP(a_idx_in_record, (state_q == S_DATA_HI) || (state_q == S_DATA_LO),
                  idx_q < rec_count_q, "data index beyond record")
  // final character of an item is always a newline or the end-of-file byte
  `IHX_ASSERT_IMP(a_last_char, out_valid_q && out_last_q,
                  (out_char_q == CH_NL) || (out_char_q == CH_EOF),
                  "last flag on wrong character")

endmodule
